// ===== sv/signed_decimal_formatter_top_assert.svh =====
// assertion macros for the signed decimal formatter
// used by sdf_queue and sdf_back; expects clk and arst_n in scope
`ifndef SIGNED_DECIMAL_FORMATTER_TOP_ASSERT_SVH
`define SIGNED_DECIMAL_FORMATTER_TOP_ASSERT_SVH

`ifndef SYNTHESIS

`define SDF_ASSERT_IMPLY(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sdf implication check failed");

`define SDF_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sdf next-cycle check failed");

`else

`define SDF_ASSERT_IMPLY(label, ante, cons)

`define SDF_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ===== sv/sdf_pkg.sv =====
// shared types and constants for the signed decimal formatter
// no dependencies
package sdf_pkg;

	localparam int MAG_DIGITS = 10;
	localparam int DIG_IDX_W  = 4;
	localparam int PREC_W     = 6;

	// reciprocal of ten for a 32-bit dividend, quotient = (x * RECIP10) >> 35
	localparam logic [31:0] RECIP10   = 32'hCCCC_CCCD;
	localparam int          RECIP_SHR = 35;

	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_NUL   = 8'h00;

	typedef struct packed {
		logic [MAG_DIGITS-1:0][3:0] digits;   // digits[0] is the ones digit
		logic [DIG_IDX_W-1:0]       nat;      // significant digits found
		logic [PREC_W-1:0]          ndig;     // digits to emit
		logic                       has_sign;
		logic [7:0]                 sign_ch;
	} job_t;

	typedef enum logic {
		FE_IDLE,
		FE_CONV
	} fe_state_t;

	typedef enum logic [1:0] {
		BE_IDLE,
		BE_EMPTY,
		BE_SIGN,
		BE_DIGIT
	} be_state_t;

endpackage

// ===== sv/sdf_front.sv =====
// front end: accepts a number, picks the sign and splits the magnitude into digits
// depends on sdf_pkg
module sdf_front #(
	parameter int MAX_PRECISION = 62
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [31:0]                          value,
	input  logic [sdf_pkg::PREC_W-1:0]           precision,
	input  logic                                 show_plus,
	input  logic                                 blank_sign,
	output logic                                 push,
	output sdf_pkg::job_t                        push_job,
	input  logic                                 q_full
);
	import sdf_pkg::*;

	localparam logic [PREC_W-1:0] MAX_PREC = PREC_W'(MAX_PRECISION);

	fe_state_t                  state_q, state_d;
	logic [31:0]                mag_q;
	logic [DIG_IDX_W-1:0]       nat_q;
	logic [MAG_DIGITS-1:0][3:0] digits_q;
	logic [PREC_W-1:0]          prec_q;
	logic                       has_sign_q;
	logic [7:0]                 sign_ch_q;

	logic        accept;
	logic        neg;
	logic [63:0] prod;
	logic [28:0] quot;
	logic [31:0] quot10;
	logic [3:0]  rem;
	logic        conv_step;

	assign neg    = value[31];
	assign prod   = 64'(mag_q) * 64'(RECIP10);
	assign quot   = prod[63:RECIP_SHR];
	assign quot10 = 32'({quot, 3'b000}) + 32'({quot, 1'b0});
	assign rem    = 4'(mag_q - quot10);

	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		accept    = 1'b0;
		conv_step = 1'b0;
		push      = 1'b0;
		unique case (state_q)
			FE_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					accept  = 1'b1;
					state_d = FE_CONV;
				end
			end
			FE_CONV: begin
				if (mag_q != 32'd0) begin
					conv_step = 1'b1;
				end else if (!q_full) begin
					push    = 1'b1;
					state_d = FE_IDLE;
				end
			end
			default: state_d = FE_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FE_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mag_q      <= neg ? (32'd0 - value) : value;
			nat_q      <= '0;
			prec_q     <= (precision > MAX_PREC) ? MAX_PREC : precision;
			has_sign_q <= neg | show_plus | blank_sign;
			sign_ch_q  <= neg ? CH_MINUS : (show_plus ? CH_PLUS : CH_SPACE);
		end else if (conv_step) begin
			digits_q[nat_q] <= rem;
			mag_q           <= 32'(quot);
			nat_q           <= nat_q + DIG_IDX_W'(1);
		end
	end

	always_comb begin
		push_job.digits   = digits_q;
		push_job.nat      = nat_q;
		push_job.ndig     = (PREC_W'(nat_q) > prec_q) ? PREC_W'(nat_q) : prec_q;
		push_job.has_sign = has_sign_q;
		push_job.sign_ch  = sign_ch_q;
	end

endmodule

// ===== sv/sdf_queue.sv =====
// two-entry job queue between the digit splitter and the character emitter
// depends on sdf_pkg and the assertion macro header
`include "signed_decimal_formatter_top_assert.svh"
module sdf_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  sdf_pkg::job_t wr_job,
	output logic          full,
	output logic          rd_valid,
	input  logic          rd_en,
	output sdf_pkg::job_t rd_job
);
	import sdf_pkg::*;

	job_t       slots_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full     = (count_q == 2'd2);
	assign rd_valid = (count_q != 2'd0);
	assign rd_job   = slots_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (rd_en) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + 2'(wr_en) - 2'(rd_en);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			slots_q[wr_ptr_q] <= wr_job;
		end
	end

	`SDF_ASSERT_IMPLY(a_no_push_when_full, wr_en, !full)
	`SDF_ASSERT_IMPLY(a_no_pop_when_empty, rd_en, rd_valid)
	`SDF_ASSERT_IMPLY(a_count_bound, 1'b1, count_q != 2'd3)

endmodule

// ===== sv/sdf_back.sv =====
// back end: walks one job and emits its characters through an output register
// depends on sdf_pkg and the assertion macro header
`include "signed_decimal_formatter_top_assert.svh"
module sdf_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_valid,
	output logic          q_ready,
	input  sdf_pkg::job_t q_job,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [7:0]    out_char,
	output logic          out_last,
	output logic          out_empty
);
	import sdf_pkg::*;

	be_state_t         state_q, state_d;
	job_t              job_q;
	logic [PREC_W-1:0] idx_q;
	logic              valid_q;
	logic [7:0]        char_q;
	logic              last_q;
	logic              empty_q;

	logic              adv;
	logic              load;
	logic              emit;
	logic [7:0]        ch;
	logic              lst;
	logic              emp;
	logic [PREC_W-1:0] pos;
	logic              last_dig;
	logic              in_nat;
	logic [3:0]        dig;

	assign adv      = !valid_q || out_ready;
	assign pos      = job_q.ndig - PREC_W'(1) - idx_q;
	assign last_dig = ((idx_q + PREC_W'(1)) == job_q.ndig);
	assign in_nat   = (pos < PREC_W'(job_q.nat));
	// leading positions beyond the significant digits are zero padding
	assign dig      = in_nat ? job_q.digits[pos[DIG_IDX_W-1:0]] : 4'd0;

	always_comb begin
		state_d = state_q;
		q_ready = 1'b0;
		load    = 1'b0;
		emit    = 1'b0;
		ch      = CH_NUL;
		lst     = 1'b0;
		emp     = 1'b0;
		unique case (state_q)
			BE_IDLE: begin
				q_ready = 1'b1;
				if (q_valid) begin
					load = 1'b1;
					if (q_job.has_sign) begin
						state_d = BE_SIGN;
					end else if (q_job.ndig == '0) begin
						state_d = BE_EMPTY;
					end else begin
						state_d = BE_DIGIT;
					end
				end
			end
			BE_EMPTY: begin
				if (adv) begin
					emit    = 1'b1;
					lst     = 1'b1;
					emp     = 1'b1;
					state_d = BE_IDLE;
				end
			end
			BE_SIGN: begin
				if (adv) begin
					emit    = 1'b1;
					ch      = job_q.sign_ch;
					lst     = (job_q.ndig == '0);
					state_d = (job_q.ndig == '0) ? BE_IDLE : BE_DIGIT;
				end
			end
			BE_DIGIT: begin
				if (adv) begin
					emit = 1'b1;
					ch   = CH_ZERO | {4'd0, dig};
					lst  = last_dig;
					if (last_dig) begin
						state_d = BE_IDLE;
					end
				end
			end
			default: state_d = BE_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BE_IDLE;
			valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (emit) begin
				valid_q <= 1'b1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			job_q <= q_job;
			idx_q <= '0;
		end else if (emit && state_q == BE_DIGIT) begin
			idx_q <= idx_q + PREC_W'(1);
		end
		if (emit) begin
			char_q  <= ch;
			last_q  <= lst;
			empty_q <= emp;
		end
	end

	assign out_valid = valid_q;
	assign out_char  = char_q;
	assign out_last  = last_q;
	assign out_empty = empty_q;

	`SDF_ASSERT_IMPLY(a_empty_is_last, valid_q && empty_q, last_q)
	`SDF_ASSERT_IMPLY(a_digit_idx_range, state_q == BE_DIGIT, idx_q < job_q.ndig)
	`SDF_ASSERT_NEXT(a_load_leaves_idle, load, state_q != BE_IDLE)

endmodule

// ===== sv/signed_decimal_formatter_top.sv =====
// signed decimal formatter top level: digit splitter, job queue, character emitter
// depends on sdf_pkg, sdf_front, sdf_queue, sdf_back
//
// channel   dir   tdata                                     tuser       tlast
// s_axis    in    value, precision, show_plus, blank_sign   -           -
// m_axis    out   char_out                                  empty_res   last
//
// the splitter turns a number into its n significant digits (0 to 10),
// one digit per cycle from a reciprocal-of-ten multiplier loop
// the emitter sends k = 1 to 63 characters per number, one per cycle while not stalled
// a two-entry queue lets the next number be split while the current one is emitted
// m_axis_tready low holds the output register and, behind it, the emitter and queue
// reset is asynchronous and clears all control state; no clearing pass is needed
module signed_decimal_formatter_top #(
	parameter int MAX_PRECISION = 62
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,   // value[31:0], precision[37:32], show_plus[38], blank_sign[39]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,   // char_out[7:0]
	output logic        m_axis_tuser,   // empty_res[0]
	output logic        m_axis_tlast
);
	import sdf_pkg::*;

	logic push;
	job_t push_job;
	logic q_full;
	logic q_valid;
	logic q_ready;
	job_t q_job;

	sdf_front #(
		.MAX_PRECISION (MAX_PRECISION)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.value      (s_axis_tdata[31:0]),
		.precision  (s_axis_tdata[37:32]),
		.show_plus  (s_axis_tdata[38]),
		.blank_sign (s_axis_tdata[39]),
		.push       (push),
		.push_job   (push_job),
		.q_full     (q_full)
	);

	sdf_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (push),
		.wr_job   (push_job),
		.full     (q_full),
		.rd_valid (q_valid),
		.rd_en    (q_valid && q_ready),
		.rd_job   (q_job)
	);

	sdf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_ready   (q_ready),
		.q_job     (q_job),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_char  (m_axis_tdata),
		.out_last  (m_axis_tlast),
		.out_empty (m_axis_tuser)
	);

endmodule

// ===== bench/tb.sv =====
// testbench for signed_decimal_formatter_top: a directed table, then random numbers
// under sender and receiver idling, every character checked against typed text or a local formatter
// depends on sdf_pkg and the formatter rtl
module tb;
	import sdf_pkg::*;

	localparam int MAX_PREC    = 62;
	localparam int PHASE_ITEMS = 137;
	localparam int QUIET_LIMIT = 2000;

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
		logic       empty;
	} text_char_t;

	typedef struct {
		logic [31:0] value;
		logic [5:0]  precision;
		logic        show_plus;
		logic        blank_sign;
		bit          typed;
		string       text;
	} number_case_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata;    // value[31:0], precision[37:32], show_plus[38], blank_sign[39]
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [7:0]  m_axis_tdata;    // char_out[7:0]
	logic        m_axis_tuser;    // empty_res[0]
	logic        m_axis_tlast;

	text_char_t pending_chars[$];
	int         mismatches = 0;
	int         quiet_cycles = 0;
	int         src_idle_pct = 0;
	int         sink_idle_pct = 0;

	// typed rows carry the text by hand; the rest go through format_number
	number_case_t directed_cases [19] = '{
		'{32'd0,          6'd0,  1'b0, 1'b0, 1'b1, ""},
		'{32'd0,          6'd0,  1'b1, 1'b0, 1'b1, "+"},
		'{32'd0,          6'd0,  1'b0, 1'b1, 1'b1, " "},
		'{32'd0,          6'd0,  1'b1, 1'b1, 1'b1, "+"},
		'{32'd0,          6'd1,  1'b0, 1'b0, 1'b1, "0"},
		'{32'h8000_0000,  6'd1,  1'b0, 1'b0, 1'b1, "-2147483648"},
		'{32'h7FFF_FFFF,  6'd1,  1'b1, 1'b0, 1'b1, "+2147483647"},
		'{32'hFFFF_FFFF,  6'd0,  1'b1, 1'b1, 1'b1, "-1"},
		'{32'd1,          6'd0,  1'b0, 1'b1, 1'b1, " 1"},
		'{32'd42,         6'd5,  1'b0, 1'b0, 1'b1, "00042"},
		'{32'd1000000000, 6'd10, 1'b0, 1'b0, 1'b1, "1000000000"},
		'{32'd999999999,  6'd10, 1'b0, 1'b1, 1'b1, " 0999999999"},
		'{32'd123,        6'd2,  1'b1, 1'b0, 1'b1, "+123"},
		'{-32'sd5,        6'd3,  1'b1, 1'b1, 1'b1, "-005"},
		'{-32'sd42,       6'd62, 1'b0, 1'b0, 1'b0, ""},
		'{32'd7,          6'd63, 1'b0, 1'b0, 1'b0, ""},
		'{32'd0,          6'd63, 1'b1, 1'b0, 1'b0, ""},
		'{32'h8000_0000,  6'd63, 1'b1, 1'b1, 1'b0, ""},
		'{32'd0,          6'd62, 1'b0, 1'b0, 1'b0, ""}
	};

	signed_decimal_formatter_top #(
		.MAX_PRECISION(MAX_PREC)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast)
	);

	always #5 clk = ~clk;

	// expected characters of one number, sign first, digits most significant first
	task automatic format_number(input logic [39:0] word);
		logic [31:0] mag;
		logic [3:0]  digs [MAG_DIGITS];
		logic [7:0]  sign_ch;
		int          prec;
		int          nsig;
		int          width;
		int          k;
		prec = (word[37:32] > MAX_PREC) ? MAX_PREC : int'(word[37:32]);
		mag  = word[31] ? 32'd0 - word[31:0] : word[31:0];
		nsig = 0;
		while (mag != 32'd0) begin
			digs[nsig] = 4'(mag % 32'd10);
			mag = mag / 32'd10;
			nsig++;
		end
		width = (nsig > prec) ? nsig : prec;
		if (word[31])
			sign_ch = CH_MINUS;
		else if (word[38])
			sign_ch = CH_PLUS;
		else if (word[39])
			sign_ch = CH_SPACE;
		else
			sign_ch = CH_NUL;
		if (sign_ch == CH_NUL && width == 0) begin
			pending_chars.push_back('{CH_NUL, 1'b1, 1'b1});
		end else begin
			if (sign_ch != CH_NUL)
				pending_chars.push_back('{sign_ch, width == 0, 1'b0});
			for (k = width - 1; k >= 0; k--) begin
				pending_chars.push_back('{(k < nsig) ? CH_ZERO + 8'(digs[k]) : CH_ZERO,
					k == 0, 1'b0});
			end
		end
	endtask

	function automatic logic [39:0] random_number();
		logic [31:0] v;
		logic [31:0] tens;
		logic [5:0]  p;
		int          pick;
		pick = $urandom_range(9);
		case (pick)
			0, 1: v = $urandom;
			2:    v = $urandom_range(999);
			3:    v = 32'd0 - $urandom_range(999);
			4: begin
				// around a power of ten, either sign
				tens = 32'd1;
				repeat ($urandom_range(9)) tens = tens * 32'd10;
				v = tens + $urandom_range(2) - 32'd1;
				if ($urandom_range(1)) v = 32'd0 - v;
			end
			5:    v = 32'd0;
			6: begin
				case ($urandom_range(3))
					0: v = 32'h8000_0000;
					1: v = 32'h7FFF_FFFF;
					2: v = 32'hFFFF_FFFF;
					default: v = 32'h8000_0001;
				endcase
			end
			default: begin
				v = $urandom >> $urandom_range(31);
				if ($urandom_range(1)) v = 32'd0 - v;
			end
		endcase
		pick = $urandom_range(99);
		if (pick < 80)
			p = 6'($urandom_range(12));
		else if (pick < 95)
			p = 6'($urandom_range(40, 13));
		else
			p = 6'($urandom_range(63, 41));
		return {1'($urandom_range(1)), 1'($urandom_range(1)), p, v};
	endfunction

	// enters and leaves at a falling edge; tvalid stays high between back-to-back items
	task automatic send_number(input logic [39:0] word, input bit typed, input string text);
		int k;
		while ($urandom_range(99) < src_idle_pct) begin
			s_axis_tvalid = 1'b0;
			@(negedge clk);
		end
		s_axis_tdata  = word;
		s_axis_tvalid = 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		if (!typed) begin
			format_number(word);
		end else if (text.len() == 0) begin
			pending_chars.push_back('{CH_NUL, 1'b1, 1'b1});
		end else begin
			for (k = 0; k < text.len(); k++)
				pending_chars.push_back('{text[k], k == text.len() - 1, 1'b0});
		end
		@(negedge clk);
	endtask

	task automatic wait_for_drain();
		s_axis_tvalid = 1'b0;
		while (pending_chars.size() != 0) @(negedge clk);
	endtask

	always @(negedge clk) begin
		m_axis_tready = ($urandom_range(99) >= sink_idle_pct);
	end

	always @(posedge clk) begin : check_output
		text_char_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_chars.size() == 0) begin
				$display("%0t: unexpected item char %h tuser %b tlast %b", $time,
					m_axis_tdata, m_axis_tuser, m_axis_tlast);
				mismatches++;
			end else begin
				want = pending_chars.pop_front();
				if (m_axis_tdata !== want.ch) begin
					$display("%0t: char expected %h actual %h", $time, want.ch, m_axis_tdata);
					mismatches++;
				end
				if (m_axis_tlast !== want.last) begin
					$display("%0t: tlast expected %b actual %b", $time, want.last,
						m_axis_tlast);
					mismatches++;
				end
				if (m_axis_tuser !== want.empty) begin
					$display("%0t: tuser expected %b actual %b", $time, want.empty,
						m_axis_tuser);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t: no item moved for %0d cycles", $time, QUIET_LIMIT);
			$display("tb: FAIL");
			$finish;
		end
	end

	initial begin
		number_case_t row;
		int           phase;
		int           n;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		m_axis_tready = 1'b0;
		src_idle_pct  = 16;
		sink_idle_pct = 52;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		foreach (directed_cases[i]) begin
			row = directed_cases[i];
			send_number({row.blank_sign, row.show_plus, row.precision, row.value},
				row.typed, row.text);
		end
		wait_for_drain();
		for (phase = 0; phase < 3; phase++) begin
			src_idle_pct  = (phase == 0) ? 16 : (phase == 1) ? 52 : 0;
			sink_idle_pct = (phase == 0) ? 52 : (phase == 1) ? 16 : 0;
			for (n = 0; n < PHASE_ITEMS; n++) begin
				// in the first phase, hold off once midway until the output side has caught up
				if (phase == 0 && n == PHASE_ITEMS / 2)
					wait_for_drain();
				send_number(random_number(), 1'b0, "");
			end
			wait_for_drain();
		end
		repeat (20) @(negedge clk);
		if (mismatches == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

endmodule
